@@ src/h264lp_pkg.sv @@
// Shared types and constants of the length-prefixed H.264 RTP packetizer.
package h264lp_pkg;

  typedef enum logic [1:0] {
    PH_PREFIX = 2'd0,
    PH_HEADER = 2'd1,
    PH_SINGLE = 2'd2,
    PH_FRAG   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ZERO_SIZE = 2'd1,
    ST_TRUNCATED = 2'd2,
    ST_TOO_LONG  = 2'd3
  } status_t;

  localparam int unsigned OFFSET_W = 20;
  localparam int unsigned LENGTH_W = 16;
  localparam int unsigned SIZE_W   = 32;
  localparam int unsigned PLEN_W   = 3;

  localparam logic [15:0] MTU_RESET      = 16'd1400;
  localparam logic [2:0]  PREFIX_RESET   = 3'd4;
  localparam logic [7:0]  NRI_MASK       = 8'h60;
  localparam logic [7:0]  FU_A_TYPE      = 8'd28;
  localparam logic [7:0]  TYPE_MASK      = 8'h1f;
  localparam logic [7:0]  FU_START_BIT   = 8'h80;
  localparam logic [7:0]  FU_END_BIT     = 8'h40;

  localparam logic [0:0] REG_MTU        = 1'b0;
  localparam logic [0:0] REG_PREFIX_LEN = 1'b1;

  typedef struct packed {
    logic [OFFSET_W-1:0] pkt_offset;
    logic [LENGTH_W-1:0] pkt_length;
    logic                single_nal;
    logic [7:0]          fu_indicator;
    logic [7:0]          fu_header;
    logic                marker;
    status_t             status;
  } result_t;

  localparam int unsigned RESULT_W = $bits(result_t);

endpackage

@@ src/h264_length_prefixed_rtp_packetizer.sv @@
// Top level of the H.264 length-prefixed NAL to RTP packet descriptor block.
//
// Input stream: one frame byte per request; s_tlast marks the last byte of a
// frame. Each NAL is preceded by a big-endian size prefix of size_prefix_len
// bytes. Output stream: one packet descriptor per request (single-NAL packet,
// FU-A fragment, or an error report with zero length); m_tlast is the RTP
// marker on the packet that completes the frame.
// Registers via APB: 0x0 mtu (reset 1400), 0x4 size_prefix_len (reset 4).
// Throughput: one byte per cycle while s_tready is high; each byte updates the
// parser state and may produce a descriptor. The parser writes a descriptor
// into the queue at the edge that accepts its byte; the output register loads
// it from the queue once it is free or m_tready takes its descriptor.
// When the receiver stalls, the descriptor queue (FIFO_DEPTH entries) keeps
// taking results; s_tready drops only when the queue is full.
// Reset clears the parser to the start of a frame, empties the queue and
// restores the register defaults.
module h264_length_prefixed_rtp_packetizer #(
  parameter int unsigned FRAME_BYTES_MAX = 1048576,
  parameter int unsigned FIFO_DEPTH      = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,  // [7:0] data_byte
  input  logic        s_tlast,  // frame_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,  // [19:0] pkt_offset, [35:20] pkt_length,
                                // [43:36] fu_indicator, [51:44] fu_header
  output logic [2:0]  m_tuser,  // [0] single_nal, [2:1] status
  output logic        m_tlast,  // marker
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] mtu;
  logic [2:0]  size_prefix_len;
  logic        take;
  logic        f_valid;
  h264lp_pkg::result_t f_res, q_data, o_data;
  logic        q_push, q_pop, q_empty, q_full;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mtu             <= h264lp_pkg::MTU_RESET;
      size_prefix_len <= h264lp_pkg::PREFIX_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2:2])
        h264lp_pkg::REG_MTU:        mtu <= pwdata[15:0];
        h264lp_pkg::REG_PREFIX_LEN: size_prefix_len <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2:2])
      h264lp_pkg::REG_MTU:        prdata = {16'd0, mtu};
      h264lp_pkg::REG_PREFIX_LEN: prdata = {29'd0, size_prefix_len};
      default:                    prdata = 32'd0;
    endcase
  end

  assign s_tready = !q_full;
  assign take     = s_tvalid && s_tready;
  assign q_push   = take && f_valid;

  h264lp_front #(
    .FRAME_BYTES_MAX(FRAME_BYTES_MAX)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .take           (take),
    .data_byte      (s_tdata),
    .frame_end      (s_tlast),
    .mtu            (mtu),
    .size_prefix_len(size_prefix_len),
    .res_valid      (f_valid),
    .res            (f_res)
  );

  h264lp_queue #(
    .DEPTH(FIFO_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(f_res),
    .pop      (q_pop),
    .pop_data (q_data),
    .empty    (q_empty),
    .full     (q_full)
  );

  h264lp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_data (o_data)
  );

  assign m_tdata = {4'd0, o_data.fu_header, o_data.fu_indicator,
                    o_data.pkt_length, o_data.pkt_offset};
  assign m_tuser = {o_data.status, o_data.single_nal};
  assign m_tlast = o_data.marker;

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_full))
    else $error("descriptor queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(q_pop && q_empty))
    else $error("descriptor queue underflow");

  a_error_empty: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[2:1] != 2'd0) |-> (m_tdata[35:20] == 16'd0 && !m_tlast))
    else $error("error descriptor carries payload or marker");

  a_single_no_fu: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata[51:36] == 16'd0))
    else $error("single-NAL descriptor carries FU bytes");

endmodule

@@ src/h264lp_front.sv @@
// Front end: parses size prefixes and NAL bytes, produces packet descriptors.
module h264lp_front #(
  parameter int unsigned FRAME_BYTES_MAX = 1048576
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  take,
  input  logic [7:0]            data_byte,
  input  logic                  frame_end,
  input  logic [15:0]           mtu,
  input  logic [2:0]            size_prefix_len,
  output logic                  res_valid,
  output h264lp_pkg::result_t   res
);

  localparam int unsigned PW = $clog2(FRAME_BYTES_MAX) + 1;
  localparam logic [PW-1:0] POS_MAX = PW'(FRAME_BYTES_MAX);

  h264lp_pkg::phase_t phase, phase_next;
  logic [2:0]                       prefix_bytes_left, prefix_bytes_left_next;
  logic [h264lp_pkg::SIZE_W-1:0]    nal_size, nal_size_next;
  logic [h264lp_pkg::SIZE_W-1:0]    nal_bytes_left, nal_bytes_left_next;
  logic [PW-1:0]                    frame_position, frame_position_next;
  logic [h264lp_pkg::OFFSET_W-1:0]  fragment_start, fragment_start_next;
  logic [15:0]                      fragment_fill, fragment_fill_next;
  logic                             first_fragment, first_fragment_next;
  logic [7:0]                       nal_header, nal_header_next;
  logic                             discard, discard_next;

  logic [15:0] eff_mtu;
  logic [2:0]  eff_len;
  logic [2:0]  left_base;
  logic [2:0]  left_dec_p;
  logic [h264lp_pkg::SIZE_W-1:0] size_base, size_shift, bytes_dec;
  logic [15:0] fill_inc;
  logic        fits_mtu;
  logic        do_fail, end_frame;
  h264lp_pkg::status_t fail_status;
  logic [h264lp_pkg::OFFSET_W-1:0] pos20, pos20_inc;
  logic [7:0] fu_ind, fu_hdr_base;

  always_comb begin
    eff_mtu = (mtu == 16'd0) ? 16'd1 : mtu;
    if (size_prefix_len == 3'd0) begin
      eff_len = 3'd1;
    end else if (size_prefix_len > 3'd4) begin
      eff_len = 3'd4;
    end else begin
      eff_len = size_prefix_len;
    end
    left_base  = (prefix_bytes_left == 3'd0) ? eff_len : prefix_bytes_left;
    size_base  = (prefix_bytes_left == 3'd0) ? '0 : nal_size;
    left_dec_p = left_base - 3'd1;
    size_shift = {size_base[h264lp_pkg::SIZE_W-9:0], data_byte};
    bytes_dec  = nal_bytes_left - h264lp_pkg::SIZE_W'(1);
    fill_inc   = fragment_fill + 16'd1;
    fits_mtu   = (nal_size[h264lp_pkg::SIZE_W-1:16] == '0) && (nal_size[15:0] <= eff_mtu);
    pos20      = h264lp_pkg::OFFSET_W'(frame_position);
    pos20_inc  = h264lp_pkg::OFFSET_W'(frame_position + PW'(1));
    fu_ind      = (nal_header & h264lp_pkg::NRI_MASK) | h264lp_pkg::FU_A_TYPE;
    fu_hdr_base = (nal_header & h264lp_pkg::TYPE_MASK)
                  | (first_fragment ? h264lp_pkg::FU_START_BIT : 8'd0);
  end

  always_comb begin
    phase_next             = phase;
    prefix_bytes_left_next = prefix_bytes_left;
    nal_size_next          = nal_size;
    nal_bytes_left_next    = nal_bytes_left;
    frame_position_next    = frame_position;
    fragment_start_next    = fragment_start;
    fragment_fill_next     = fragment_fill;
    first_fragment_next    = first_fragment;
    nal_header_next        = nal_header;
    discard_next           = discard;
    res_valid              = 1'b0;
    res                    = '0;
    do_fail                = 1'b0;
    end_frame              = 1'b0;
    fail_status            = h264lp_pkg::ST_OK;

    if (discard) begin
      end_frame = frame_end;
    end else if (frame_position >= POS_MAX) begin
      do_fail     = 1'b1;
      fail_status = h264lp_pkg::ST_TOO_LONG;
    end else begin
      frame_position_next = frame_position + PW'(1);
      unique case (phase)
        h264lp_pkg::PH_PREFIX: begin
          prefix_bytes_left_next = left_dec_p;
          nal_size_next          = size_shift;
          if (left_dec_p != 3'd0) begin
            if (frame_end) begin
              do_fail     = 1'b1;
              fail_status = h264lp_pkg::ST_TRUNCATED;
            end
          end else if (size_shift == '0) begin
            do_fail     = 1'b1;
            fail_status = h264lp_pkg::ST_ZERO_SIZE;
          end else if (frame_end) begin
            do_fail     = 1'b1;
            fail_status = h264lp_pkg::ST_TRUNCATED;
          end else begin
            nal_bytes_left_next = size_shift;
            phase_next          = h264lp_pkg::PH_HEADER;
          end
        end
        h264lp_pkg::PH_HEADER: begin
          nal_header_next     = data_byte;
          nal_bytes_left_next = bytes_dec;
          if (fits_mtu) begin
            fragment_start_next = pos20;
            phase_next          = h264lp_pkg::PH_SINGLE;
          end else begin
            fragment_start_next = pos20_inc;
            fragment_fill_next  = 16'd0;
            first_fragment_next = 1'b1;
            phase_next          = h264lp_pkg::PH_FRAG;
          end
          if (bytes_dec == '0) begin
            // one-byte NAL is always sent whole
            phase_next       = h264lp_pkg::PH_PREFIX;
            end_frame        = frame_end;
            res_valid        = 1'b1;
            res.pkt_offset   = pos20;
            res.pkt_length   = 16'd1;
            res.single_nal   = 1'b1;
            res.marker       = frame_end;
          end else if (frame_end) begin
            do_fail     = 1'b1;
            fail_status = h264lp_pkg::ST_TRUNCATED;
          end
        end
        h264lp_pkg::PH_SINGLE: begin
          nal_bytes_left_next = bytes_dec;
          if (bytes_dec == '0) begin
            phase_next     = h264lp_pkg::PH_PREFIX;
            end_frame      = frame_end;
            res_valid      = 1'b1;
            res.pkt_offset = fragment_start;
            res.pkt_length = nal_size[15:0];
            res.single_nal = 1'b1;
            res.marker     = frame_end;
          end else if (frame_end) begin
            do_fail     = 1'b1;
            fail_status = h264lp_pkg::ST_TRUNCATED;
          end
        end
        h264lp_pkg::PH_FRAG: begin
          nal_bytes_left_next = bytes_dec;
          fragment_fill_next  = fill_inc;
          if (bytes_dec == '0) begin
            res_valid           = 1'b1;
            res.pkt_offset      = fragment_start;
            res.pkt_length      = fill_inc;
            res.fu_indicator    = fu_ind;
            res.fu_header       = fu_hdr_base | h264lp_pkg::FU_END_BIT;
            res.marker          = frame_end;
            phase_next          = h264lp_pkg::PH_PREFIX;
            first_fragment_next = 1'b1;
            fragment_fill_next  = 16'd0;
            end_frame           = frame_end;
          end else if (frame_end) begin
            do_fail     = 1'b1;
            fail_status = h264lp_pkg::ST_TRUNCATED;
          end else if (fill_inc >= eff_mtu) begin
            res_valid           = 1'b1;
            res.pkt_offset      = fragment_start;
            res.pkt_length      = fill_inc;
            res.fu_indicator    = fu_ind;
            res.fu_header       = fu_hdr_base;
            fragment_start_next = pos20_inc;
            fragment_fill_next  = 16'd0;
            first_fragment_next = 1'b0;
          end
        end
        default: begin
          phase_next = h264lp_pkg::PH_PREFIX;
        end
      endcase
    end

    if (do_fail) begin
      res_valid      = 1'b1;
      res            = '0;
      res.pkt_offset = pos20;
      res.status     = fail_status;
      if (frame_end) begin
        end_frame = 1'b1;
      end else begin
        discard_next = 1'b1;
      end
    end

    if (end_frame) begin
      phase_next             = h264lp_pkg::PH_PREFIX;
      prefix_bytes_left_next = 3'd0;
      frame_position_next    = '0;
      discard_next           = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= h264lp_pkg::PH_PREFIX;
      prefix_bytes_left <= 3'd0;
      nal_size          <= '0;
      nal_bytes_left    <= '0;
      frame_position    <= '0;
      fragment_start    <= '0;
      fragment_fill     <= 16'd0;
      first_fragment    <= 1'b1;
      nal_header        <= 8'd0;
      discard           <= 1'b0;
    end else if (take) begin
      phase             <= phase_next;
      prefix_bytes_left <= prefix_bytes_left_next;
      nal_size          <= nal_size_next;
      nal_bytes_left    <= nal_bytes_left_next;
      frame_position    <= frame_position_next;
      fragment_start    <= fragment_start_next;
      fragment_fill     <= fragment_fill_next;
      first_fragment    <= first_fragment_next;
      nal_header        <= nal_header_next;
      discard           <= discard_next;
    end
  end

endmodule

@@ src/h264lp_queue.sv @@
// Small descriptor queue between the parser and the output stage.
module h264lp_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  h264lp_pkg::result_t push_data,
  input  logic                pop,
  output h264lp_pkg::result_t pop_data,
  output logic                empty,
  output logic                full
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  h264lp_pkg::result_t slots [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign empty    = (count == '0);
  assign full     = (count == CW'(DEPTH));
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ src/h264lp_back.sv @@
// Back end: output register that presents one descriptor request at a time.
module h264lp_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  h264lp_pkg::result_t q_data,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output h264lp_pkg::result_t out_data
);

  assign q_pop = !q_empty && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data <= q_data;
    end
  end

endmodule
